// ===== sv/assert_macros.svh =====
// Assertion macros for the filter RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define FPF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FPF_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/fpf_pkg.sv =====
// Types and codes for the five-tuple policy filter.
// No dependencies.
package fpf_pkg;

	typedef struct packed {
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  proto;
	} key_t;

	localparam logic [1:0] CMD_CLASSIFY = 2'd0;
	localparam logic [1:0] CMD_WRITE    = 2'd1;
	localparam logic [1:0] CMD_DELETE   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef enum logic [1:0] {OP_NONE, OP_LOOKUP, OP_WRITE, OP_DELETE} op_t;

	typedef struct packed {
		op_t         op;
		key_t        key;
		logic        deny;
		logic [31:0] ident;
	} item_t;

	typedef struct packed {
		logic        valid;
		key_t        key;
		logic        deny;
		logic [31:0] ident;
		logic [31:0] hits;
	} entry_t;

endpackage

// ===== sv/five_tuple_policy_filter.sv =====
// Top level of the exact-match five-tuple policy filter.
// Depends on fpf_pkg, fpf_front, fpf_queue, fpf_back and assert_macros.svh.

// Each rule table command and each parsed classify scans the whole table, one entry
// per cycle through the single read port of the rule memory; a classify that failed
// to parse or an unused command skips the scan. After reset a clearing pass writes
// every entry of the rule memory before the first beat leaves the input queue.
// The front keeps accepting beats into a short queue while the table is busy, and a
// result beat waits in an output register while the next command is scanned.
`include "assert_macros.svh"
module five_tuple_policy_filter import fpf_pkg::*; #(
	parameter int POLICY_ENTRIES = 1024,
	parameter int COUNTER_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  command,
	input  logic        parse_ok,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic [15:0] source_port,
	input  logic [15:0] dest_port,
	input  logic [7:0]  protocol_number,
	input  logic        rule_action,
	input  logic [31:0] rule_ident,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        verdict,
	output logic        matched,
	output logic [31:0] matched_rule_ident,
	output logic [31:0] matched_rule_hits,
	output logic [31:0] total_packets,
	output logic [31:0] policy_hits,
	output logic [31:0] policy_misses,
	output logic [31:0] allowed_packets,
	output logic [31:0] denied_packets,
	output logic [1:0]  status
);

	logic       f_valid;
	logic       f_ready;
	item_t      f_item;
	logic       q_valid;
	logic       q_ready;
	item_t      q_item;
	logic [1:0] q_level;
	logic       clearing;

	fpf_front u_front (
		.clk, .arst_n, .req_valid, .req_ready, .command, .parse_ok,
		.source_address, .dest_address, .source_port, .dest_port,
		.protocol_number, .rule_action, .rule_ident,
		.item_valid_s1(f_valid), .item_ready(f_ready), .item_s1(f_item)
	);

	fpf_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(q_item),
		.level(q_level)
	);

	fpf_back #(.POLICY_ENTRIES(POLICY_ENTRIES), .COUNTER_BITS(COUNTER_BITS)) u_back (
		.clk, .arst_n,
		.item_valid(q_valid), .item_ready(q_ready), .item(q_item), .clearing,
		.rsp_valid, .rsp_ready, .verdict, .matched, .matched_rule_ident,
		.matched_rule_hits, .total_packets, .policy_hits, .policy_misses,
		.allowed_packets, .denied_packets, .status
	);

	`FPF_ASSERT(a_drop_needs_match, rsp_valid |-> (!verdict || matched), "drop without match")
	`FPF_ASSERT(a_status_no_match, (rsp_valid && status != ST_OK) |-> !matched, "bad status")
	`FPF_ASSERT(a_queue_bound, q_level <= 2'd2, "queue overflow")
	`FPF_ASSERT_RST(a_no_pop_clear, clearing |-> !(q_valid && q_ready), "pop while clearing")

endmodule

// ===== sv/fpf_front.sv =====
// Input stage: takes request beats and decodes them into table operations.
// Depends on fpf_pkg.
module fpf_front import fpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  command,
	input  logic        parse_ok,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic [15:0] source_port,
	input  logic [15:0] dest_port,
	input  logic [7:0]  protocol_number,
	input  logic        rule_action,
	input  logic [31:0] rule_ident,
	output logic        item_valid_s1,
	input  logic        item_ready,
	output item_t       item_s1
);

	op_t op;

	always_comb begin
		unique case (command)
			CMD_CLASSIFY: op = parse_ok ? OP_LOOKUP : OP_NONE;
			CMD_WRITE:    op = OP_WRITE;
			CMD_DELETE:   op = OP_DELETE;
			default:      op = OP_NONE;
		endcase
	end

	assign req_ready = !item_valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			item_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1.op    <= op;
			item_s1.key   <= '{saddr: source_address, daddr: dest_address,
				sport: source_port, dport: dest_port, proto: protocol_number};
			item_s1.deny  <= rule_action;
			item_s1.ident <= rule_ident;
		end
	end

endmodule

// ===== sv/fpf_queue.sv =====
// Two-entry queue of decoded operations between front and back.
// Depends on fpf_pkg.
module fpf_queue import fpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  item_t      in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output item_t      out_item,
	output logic [1:0] level
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = count_q != 2'd2;
	assign out_valid = count_q != 2'd0;
	assign out_item  = slot_q[rd_ptr_q];
	assign level     = count_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= in_item;
	end

endmodule

// ===== sv/fpf_back.sv =====
// Rule table, scan sequencer, counters and result register.
// Depends on fpf_pkg.
module fpf_back import fpf_pkg::*; #(
	parameter int POLICY_ENTRIES = 1024,
	parameter int COUNTER_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        clearing,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        verdict,
	output logic        matched,
	output logic [31:0] matched_rule_ident,
	output logic [31:0] matched_rule_hits,
	output logic [31:0] total_packets,
	output logic [31:0] policy_hits,
	output logic [31:0] policy_misses,
	output logic [31:0] allowed_packets,
	output logic [31:0] denied_packets,
	output logic [1:0]  status
);

	localparam int IDX_W = (POLICY_ENTRIES > 1) ? $clog2(POLICY_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POLICY_ENTRIES - 1);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_APPLY} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   addr_q;
	item_t              cur_q;
	logic               found_q;
	logic [IDX_W-1:0]   match_idx_q;
	entry_t             match_word_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	entry_t             rdata_s1;
	entry_t             mem [POLICY_ENTRIES];
	logic [COUNTER_BITS-1:0] cnt_total_q, cnt_hits_q, cnt_miss_q, cnt_allow_q, cnt_deny_q;

	logic               apply_go;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	logic               key_hit;
	logic [31:0]        hits_inc;

	assign item_ready = state_q == S_IDLE;
	assign clearing   = state_q == S_CLEAR;
	assign apply_go   = (state_q == S_APPLY) && (!rsp_valid || rsp_ready);
	assign key_hit    = rd_vld_s1 && rdata_s1.valid && (rdata_s1.key == cur_q.key);
	assign hits_inc   = match_word_q.hits + 32'd1;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end else if (apply_go) begin
			case (cur_q.op)
				OP_LOOKUP: begin
					wr_en        = found_q;
					wr_addr      = match_idx_q;
					wr_data      = match_word_q;
					wr_data.hits = hits_inc;
				end
				OP_WRITE: begin
					wr_en   = found_q || free_q;
					wr_addr = found_q ? match_idx_q : free_idx_q;
					wr_data = '{valid: 1'b1, key: cur_q.key, deny: cur_q.deny,
						ident: cur_q.ident, hits: 32'd0};
				end
				OP_DELETE: begin
					wr_en         = found_q;
					wr_addr       = match_idx_q;
					wr_data       = match_word_q;
					wr_data.valid = 1'b0;
				end
				default: wr_en = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			cur_q        <= '0;
			found_q      <= 1'b0;
			match_idx_q  <= '0;
			match_word_q <= '0;
			free_q       <= 1'b0;
			free_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			cnt_total_q  <= '0;
			cnt_hits_q   <= '0;
			cnt_miss_q   <= '0;
			cnt_allow_q  <= '0;
			cnt_deny_q   <= '0;
			rsp_valid    <= 1'b0;
			verdict      <= 1'b0;
			matched      <= 1'b0;
			matched_rule_ident <= '0;
			matched_rule_hits  <= '0;
			status       <= ST_OK;
		end else begin
			rd_vld_s1 <= state_q == S_SCAN;
			rd_idx_s1 <= addr_q;
			if (key_hit && !found_q) begin
				found_q      <= 1'b1;
				match_idx_q  <= rd_idx_s1;
				match_word_q <= rdata_s1;
			end
			if (rd_vld_s1 && !rdata_s1.valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
			if (rsp_ready) rsp_valid <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_IDX) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						cur_q   <= item;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						addr_q  <= '0;
						state_q <= (item.op == OP_NONE) ? S_APPLY : S_SCAN;
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_IDX) begin
						addr_q  <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_APPLY;
				S_APPLY: begin
					if (apply_go) begin
						rsp_valid          <= 1'b1;
						verdict            <= 1'b0;
						matched            <= 1'b0;
						matched_rule_ident <= '0;
						matched_rule_hits  <= '0;
						status             <= ST_OK;
						case (cur_q.op)
							OP_LOOKUP: begin
								cnt_total_q <= cnt_total_q + 1'b1;
								if (found_q) begin
									cnt_hits_q         <= cnt_hits_q + 1'b1;
									matched            <= 1'b1;
									matched_rule_ident <= match_word_q.ident;
									matched_rule_hits  <= hits_inc;
									verdict            <= match_word_q.deny;
									if (match_word_q.deny) cnt_deny_q <= cnt_deny_q + 1'b1;
									else cnt_allow_q <= cnt_allow_q + 1'b1;
								end else begin
									cnt_miss_q  <= cnt_miss_q + 1'b1;
									cnt_allow_q <= cnt_allow_q + 1'b1;
								end
							end
							OP_WRITE:  if (!found_q && !free_q) status <= ST_FULL;
							OP_DELETE: if (!found_q) status <= ST_NOT_FOUND;
							default:   status <= ST_OK;
						endcase
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign total_packets   = 32'(cnt_total_q);
	assign policy_hits     = 32'(cnt_hits_q);
	assign policy_misses   = 32'(cnt_miss_q);
	assign allowed_packets = 32'(cnt_allow_q);
	assign denied_packets  = 32'(cnt_deny_q);

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for five_tuple_policy_filter: classify, write and delete beats
// with a local table and counter predictor, under several sender and receiver idling mixes.
// Depends on fpf_pkg and the filter RTL.
module tb_top;
	import fpf_pkg::*;

	localparam int ENTRIES   = 1024;
	localparam int WDOG_LIMIT = 40000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic        verdict;
		logic        matched;
		logic [31:0] ident;
		logic [31:0] hits;
		logic [31:0] total;
		logic [31:0] phits;
		logic [31:0] pmiss;
		logic [31:0] allowed;
		logic [31:0] denied;
		logic [1:0]  status;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [1:0]  command = CMD_CLASSIFY;
	logic        parse_ok = 1'b0;
	logic [31:0] source_address = '0;
	logic [31:0] dest_address = '0;
	logic [15:0] source_port = '0;
	logic [15:0] dest_port = '0;
	logic [7:0]  protocol_number = '0;
	logic        rule_action = 1'b0;
	logic [31:0] rule_ident = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic        verdict, matched;
	logic [31:0] matched_rule_ident, matched_rule_hits, total_packets, policy_hits;
	logic [31:0] policy_misses, allowed_packets, denied_packets;
	logic [1:0]  status;

	five_tuple_policy_filter u_dut (.*);

	// predictor state
	logic        tbl_valid [ENTRIES];
	key_t        tbl_key   [ENTRIES];
	logic        tbl_deny  [ENTRIES];
	logic [31:0] tbl_ident [ENTRIES];
	logic [31:0] tbl_hits  [ENTRIES];
	logic [31:0] cnt_total, cnt_hits, cnt_miss, cnt_allow, cnt_deny;

	verdict_t verdict_q[$];
	key_t     key_pool[16];
	int       send_idle_pct, stall_pct, hold_off;
	int       errors, mismatches, beats_in, beats_out, idle_run;
	int       n_full, n_notfound, n_drop, n_hit;

	initial forever #2 clk = ~clk;

	function automatic int find_rule(key_t k);
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && tbl_key[i] == k) return i;
		return -1;
	endfunction

	function automatic int free_slots();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (!tbl_valid[i]) n++;
		return n;
	endfunction

	function automatic verdict_t apply_filter(logic [1:0] cmd, logic pok, key_t k, logic deny,
			logic [31:0] id);
		verdict_t r;
		int idx;
		r = '0;
		case (cmd)
			CMD_CLASSIFY: begin
				if (pok) begin
					idx = find_rule(k);
					cnt_total++;
					if (idx >= 0) begin
						cnt_hits++;
						tbl_hits[idx]++;
						r.matched = 1'b1;
						r.ident = tbl_ident[idx];
						r.hits = tbl_hits[idx];
						if (tbl_deny[idx]) begin
							cnt_deny++;
							r.verdict = 1'b1;
						end else begin
							cnt_allow++;
						end
					end else begin
						cnt_miss++;
						cnt_allow++;
					end
				end
			end
			CMD_WRITE: begin
				idx = find_rule(k);
				if (idx < 0)
					for (int i = 0; i < ENTRIES; i++)
						if (!tbl_valid[i]) begin
							idx = i;
							break;
						end
				if (idx < 0) begin
					r.status = ST_FULL;
				end else begin
					tbl_valid[idx] = 1'b1;
					tbl_key[idx] = k;
					tbl_deny[idx] = deny;
					tbl_ident[idx] = id;
					tbl_hits[idx] = '0;
				end
			end
			CMD_DELETE: begin
				idx = find_rule(k);
				if (idx < 0) r.status = ST_NOT_FOUND;
				else tbl_valid[idx] = 1'b0;
			end
			default: ;
		endcase
		r.total = cnt_total;
		r.phits = cnt_hits;
		r.pmiss = cnt_miss;
		r.allowed = cnt_allow;
		r.denied = cnt_deny;
		return r;
	endfunction

	function automatic key_t rand_key();
		return {$urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom)};
	endfunction

	task automatic send_beat(logic [1:0] cmd, logic pok, key_t k, logic deny, logic [31:0] id);
		verdict_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		command <= cmd;
		parse_ok <= pok;
		{source_address, dest_address, source_port, dest_port, protocol_number} <= k;
		rule_action <= deny;
		rule_ident <= id;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		r = apply_filter(cmd, pok, k, deny, id);
		verdict_q.push_back(r);
		beats_in++;
		if (r.status == ST_FULL) n_full++;
		if (r.status == ST_NOT_FOUND) n_notfound++;
		if (r.verdict) n_drop++;
		if (r.matched) n_hit++;
	endtask

	task automatic stop_sending();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (verdict_q.size() != 0) @(posedge clk);
	endtask

	// receiver and checker
	always @(posedge clk) begin
		verdict_t got, want;
		if (rsp_valid && rsp_ready) begin
			got = {verdict, matched, matched_rule_ident, matched_rule_hits, total_packets,
				policy_hits, policy_misses, allowed_packets, denied_packets, status};
			beats_out++;
			if (verdict_q.size() == 0) begin
				errors++;
				$display("[%0t] result beat with nothing expected", $realtime);
			end else begin
				want = verdict_q.pop_front();
				if (got != want) begin
					errors++;
					mismatches++;
					if (mismatches <= 10) begin
						$display("[%0t] mismatch (exp/act): verdict %0d/%0d matched %0d/%0d",
							$realtime, want.verdict, got.verdict, want.matched, got.matched);
						$display("  ident %h/%h hits %0d/%0d total %0d/%0d phits %0d/%0d",
							want.ident, got.ident, want.hits, got.hits, want.total,
							got.total, want.phits, got.phits);
						$display("  miss %0d/%0d allow %0d/%0d deny %0d/%0d status %0d/%0d",
							want.pmiss, got.pmiss, want.allowed, got.allowed,
							want.denied, got.denied, want.status, got.status);
					end
				end
			end
		end
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_run <= 0;
		end else if (idle_run >= WDOG_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", WDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	task automatic test_directed();
		key_t ka, kb, kc, kz, kf;
		ka = rand_key();
		kb = rand_key();
		kc = rand_key();
		kz = '0;
		kf = '1;
		send_beat(CMD_CLASSIFY, 1'b1, ka, 1'b0, '0);
		send_beat(CMD_WRITE, 1'b0, ka, 1'b0, 32'hFFFF_FFFF);
		send_beat(CMD_CLASSIFY, 1'b1, ka, 1'b1, '0);
		send_beat(CMD_CLASSIFY, 1'b1, ka, 1'b0, '0);
		send_beat(CMD_CLASSIFY, 1'b0, ka, 1'b0, '0);
		send_beat(CMD_WRITE, 1'b1, kb, 1'b1, 32'h0000_0001);
		send_beat(CMD_CLASSIFY, 1'b1, kb, 1'b0, '1);
		send_beat(CMD_WRITE, 1'b0, ka, 1'b1, 32'h8000_0000);
		send_beat(CMD_CLASSIFY, 1'b1, ka, 1'b0, '0);
		send_beat(CMD_DELETE, 1'b1, kc, 1'b1, '1);
		send_beat(CMD_DELETE, 1'b0, ka, 1'b0, '0);
		send_beat(CMD_CLASSIFY, 1'b1, ka, 1'b0, '0);
		send_beat(CMD_UNUSED, 1'b1, kb, 1'b1, '1);
		send_beat(CMD_WRITE, 1'b0, kz, 1'b0, '0);
		send_beat(CMD_WRITE, 1'b1, kf, 1'b1, '1);
		send_beat(CMD_CLASSIFY, 1'b1, kz, 1'b1, '1);
		send_beat(CMD_CLASSIFY, 1'b1, kf, 1'b0, '0);
		send_beat(CMD_CLASSIFY, 1'b1, {kf[103:1], 1'b0}, 1'b0, '0);
		send_beat(CMD_WRITE, 1'b0, ka, 1'b0, 32'h1234_5678);
		send_beat(CMD_CLASSIFY, 1'b1, ka, 1'b0, '0);
		stop_sending();
	endtask

	task automatic test_random(int n, int idle_pct, int stall);
		int sel;
		key_t k;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		repeat (n) begin
			k = ($urandom_range(9) == 0) ? rand_key() : key_pool[$urandom_range(15)];
			sel = $urandom_range(99);
			send_beat(sel < 60 ? CMD_CLASSIFY : sel < 80 ? CMD_WRITE :
				sel < 95 ? CMD_DELETE : CMD_UNUSED,
				$urandom_range(99) < 85, k, 1'($urandom), $urandom);
		end
		stop_sending();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off = 8000;
		repeat (10) send_beat(CMD_CLASSIFY, 1'b1, key_pool[$urandom_range(15)], 1'b0, '0);
		stop_sending();
		drain();
		send_beat(CMD_CLASSIFY, 1'b1, key_pool[0], 1'b0, '0);
		stop_sending();
	endtask

	task automatic test_table_full();
		key_t k;
		send_idle_pct = 0;
		stall_pct = 20;
		while (free_slots() > 0) begin
			k = rand_key();
			send_beat(CMD_WRITE, 1'($urandom), k, 1'($urandom), $urandom);
		end
		send_beat(CMD_WRITE, 1'b1, rand_key(), 1'b1, $urandom);
		send_beat(CMD_CLASSIFY, 1'b1, k, 1'b0, '0);
		send_beat(CMD_DELETE, 1'b0, tbl_key[ENTRIES / 2], 1'b0, '0);
		send_beat(CMD_WRITE, 1'b0, rand_key(), 1'b0, $urandom);
		send_beat(CMD_WRITE, 1'b0, rand_key(), 1'b0, $urandom);
		stop_sending();
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_deny[i] = 1'b0;
			tbl_ident[i] = '0;
			tbl_hits[i] = '0;
		end
		{cnt_total, cnt_hits, cnt_miss, cnt_allow, cnt_deny} = '0;
		{errors, mismatches, beats_in, beats_out, idle_run, hold_off} = '0;
		{n_full, n_notfound, n_drop, n_hit} = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		foreach (key_pool[i]) key_pool[i] = rand_key();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(160, 0, 0);
		test_random(160, 86, 0);
		test_random(160, 0, 86);
		test_random(160, 36, 36);
		test_backpressure();
		test_random(60, 0, 0);
		test_table_full();

		drain();
		repeat (2000) @(posedge clk);
		$display("Covered %0d request beats, %0d results: %0d hits, %0d drops,",
			beats_in, beats_out, n_hit, n_drop);
		$display("%0d table-full writes, %0d deletes of absent keys, %0d errors",
			n_full, n_notfound, errors);
		if (errors == 0 && verdict_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
